// ===== design/adcu_pkg.sv =====
package adcu_pkg;

  // layout
  localparam int MODE_A_CHANNELS = 32;
  localparam int MODE_B_CHANNELS = 40;
  localparam int PEDESTAL_GROUPS = 20;
  localparam logic [7:0] HDR_BYTES  = 8'd32;
  localparam logic [7:0] PED_BASE   = 8'd64;
  localparam logic [7:0] OFFS_MAX   = 8'd255;
  localparam logic [2:0] A_PH_LAST  = 3'd6;
  localparam logic [2:0] B_PH_LAST  = 3'd4;
  localparam logic [1:0] G_PH_LAST  = 2'd2;

  localparam int QueueDepth = 4;

  // record modes
  localparam logic MODE_SEVEN = 1'b0;
  localparam logic MODE_FIVE  = 1'b1;

  // configuration
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 40;
  localparam logic [CfgAddrW-1:0] CFG_MODE    = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_ENABLE  = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_EXP_LEN = 2'd2;
  localparam logic [39:0] RST_ENABLE  = 40'hFF_FFFF_FFFF;
  localparam logic [31:0] RST_EXP_LEN = 32'd256;

  // output packing
  localparam int OutDataW   = 128;
  localparam int TD_CHAN    = 0;
  localparam int TD_VALUE   = 6;
  localparam int TD_PEAK    = 65;
  localparam int TD_TIME    = 89;
  localparam int TD_TRIG    = 121;

  typedef enum logic [3:0] {
    KIND_LENGTH     = 4'd0,
    KIND_TRIGTYPE   = 4'd1,
    KIND_TRIGNUM    = 4'd2,
    KIND_TRIGTIME   = 4'd3,
    KIND_MODULE     = 4'd4,
    KIND_LOCALNUM   = 4'd5,
    KIND_PATTERN    = 4'd6,
    KIND_LOCALTIME  = 4'd7,
    KIND_CHANNEL    = 4'd8,
    KIND_PEDESTAL   = 4'd9,
    KIND_ZEROED     = 4'd10,
    KIND_LENGTH_ERR = 4'd11,
    KIND_END        = 4'd12
  } kind_e;

  // classified input byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       live;
    logic [7:0] offs;
    logic       mode;
    logic [4:0] a_idx;
    logic [2:0] a_ph;
    logic       a_in;
    logic [5:0] b_idx;
    logic [2:0] b_ph;
    logic       b_in;
    logic [5:0] g_idx;
    logic [1:0] g_ph;
    logic       g_in;
  } item_t;

  typedef struct packed {
    kind_e        kind;
    logic [5:0]   chan;
    logic [58:0]  value;
    logic [23:0]  peak;
    logic [31:0]  tim;
    logic         trig;
    logic         last;
  } res_t;

endpackage

// ===== design/adcu_front.sv =====
module adcu_front
  import adcu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_data_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  logic       mode_i,
  input  logic       q_full_i,
  output logic       push_o,
  output item_t      item_o
);

  logic [7:0] offs_q, offs_d;
  logic       past_q, past_d;
  logic [4:0] a_idx_q, a_idx_d;
  logic [2:0] a_ph_q, a_ph_d;
  logic [5:0] b_idx_q, b_idx_d;
  logic [2:0] b_ph_q, b_ph_d;
  logic [5:0] g_idx_q, g_idx_d;
  logic [1:0] g_ph_q, g_ph_d;
  logic       in_chan, in_ped;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign in_chan    = offs_q >= HDR_BYTES;
  assign in_ped     = offs_q >= PED_BASE;

  always_comb begin
    item_o       = '0;
    item_o.data  = in_data_i;
    item_o.last  = in_last_i;
    item_o.live  = !past_q;
    item_o.offs  = offs_q;
    item_o.mode  = mode_i;
    item_o.a_idx = a_idx_q;
    item_o.a_ph  = a_ph_q;
    item_o.a_in  = in_chan && (int'(a_idx_q) < MODE_A_CHANNELS);
    item_o.b_idx = b_idx_q;
    item_o.b_ph  = b_ph_q;
    item_o.b_in  = in_chan && (int'(b_idx_q) < MODE_B_CHANNELS);
    item_o.g_idx = g_idx_q;
    item_o.g_ph  = g_ph_q;
    item_o.g_in  = in_ped && (int'(g_idx_q) < PEDESTAL_GROUPS);
  end

  always_comb begin
    offs_d  = offs_q;
    past_d  = past_q;
    a_idx_d = a_idx_q;
    a_ph_d  = a_ph_q;
    b_idx_d = b_idx_q;
    b_ph_d  = b_ph_q;
    g_idx_d = g_idx_q;
    g_ph_d  = g_ph_q;
    if (push_o) begin
      if (in_last_i) begin
        offs_d  = '0;
        past_d  = 1'b0;
        a_idx_d = '0;
        a_ph_d  = '0;
        b_idx_d = '0;
        b_ph_d  = '0;
        g_idx_d = '0;
        g_ph_d  = '0;
      end else if (!past_q) begin
        if (offs_q == OFFS_MAX) begin
          past_d = 1'b1;
        end else begin
          offs_d = offs_q + 8'd1;
          if (in_chan) begin
            if (a_ph_q == A_PH_LAST) begin
              a_ph_d  = '0;
              a_idx_d = a_idx_q + 5'd1;
            end else begin
              a_ph_d = a_ph_q + 3'd1;
            end
            if (b_ph_q == B_PH_LAST) begin
              b_ph_d  = '0;
              b_idx_d = b_idx_q + 6'd1;
            end else begin
              b_ph_d = b_ph_q + 3'd1;
            end
          end
          if (in_ped) begin
            if (g_ph_q == G_PH_LAST) begin
              g_ph_d  = '0;
              g_idx_d = g_idx_q + 6'd1;
            end else begin
              g_ph_d = g_ph_q + 2'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offs_q  <= '0;
      past_q  <= 1'b0;
      a_idx_q <= '0;
      a_ph_q  <= '0;
      b_idx_q <= '0;
      b_ph_q  <= '0;
      g_idx_q <= '0;
      g_ph_q  <= '0;
    end else begin
      offs_q  <= offs_d;
      past_q  <= past_d;
      a_idx_q <= a_idx_d;
      a_ph_q  <= a_ph_d;
      b_idx_q <= b_idx_d;
      b_ph_q  <= b_ph_d;
      g_idx_q <= g_idx_d;
      g_ph_q  <= g_ph_d;
    end
  end

endmodule

// ===== design/adcu_fifo.sv =====
module adcu_fifo
  import adcu_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  item_t            mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== design/adcu_back.sv =====
module adcu_back
  import adcu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  item_t       item_i,
  input  logic        empty_i,
  output logic        pop_o,
  input  logic [39:0] enable_i,
  input  logic [31:0] exp_len_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output res_t        out_o
);

  logic [63:0] hdr_q, hdr_d;
  logic [23:0] peak_q, peak_d;
  logic [31:0] time_q, time_d;
  logic [11:0] ped_q, ped_d;
  logic [31:0] pat_q, pat_d;
  logic        lbad_q, lbad_d;
  logic [1:0]  ridx_q, ridx_d;
  logic        ov_q, ov_d;
  res_t        out_q, out_d;

  logic [7:0]  b;
  logic [7:0]  o;
  logic [63:0] byte64;
  logic [17:0] b_k;
  logic [2:0]  sh;
  logic [63:0] or_val, add_val;
  logic [31:0] ta_sum;
  logic [11:0] ped_val;
  logic        bad;
  logic        p_v, s_v, e_v;
  res_t        p, s, e, r0, r1, r_sel;
  logic [1:0]  cnt;
  logic        head, free, load;

  assign b      = item_i.data;
  assign o      = item_i.offs;
  assign byte64 = {56'b0, b};
  assign b_k    = 18'(b) * 18'd1000;

  always_comb begin
    case (o) inside
      8'd1, 8'd2, 8'd3:                  sh = 3'(o);
      8'd8, 8'd9, 8'd10:                 sh = 3'(o - 8'd7);
      8'd18, 8'd19, 8'd20:               sh = 3'(o - 8'd17);
      8'd22, 8'd23, 8'd24:               sh = 3'(o - 8'd21);
      8'd12, 8'd13, 8'd14:               sh = 3'(o - 8'd12);
      8'd26, 8'd27, 8'd28, 8'd29, 8'd30,
      8'd31:                             sh = 3'(o - 8'd26);
      default:                           sh = 3'd0;
    endcase
  end

  assign or_val  = hdr_q | (byte64 << {sh, 3'b000});
  assign add_val = hdr_q + ({46'b0, b_k} << {sh, 3'b000});
  assign ta_sum  = time_q + 32'({46'b0, b_k} << {item_i.a_ph[1:0], 3'b000});
  assign bad     = (item_i.mode == MODE_SEVEN) && (or_val != {32'b0, exp_len_i});

  always_comb begin
    hdr_d   = hdr_q;
    peak_d  = peak_q;
    time_d  = time_q;
    ped_d   = ped_q;
    pat_d   = pat_q;
    lbad_d  = lbad_q;
    p_v     = 1'b0;
    s_v     = 1'b0;
    p       = '0;
    s       = '0;
    ped_val = '0;
    if (item_i.live) begin
      if (o < HDR_BYTES) begin
        case (o) inside
          8'd0, 8'd7, 8'd17, 8'd21: hdr_d = byte64;
          8'd1, 8'd2, 8'd8, 8'd9, 8'd18, 8'd19, 8'd22, 8'd23: hdr_d = or_val;
          8'd3: begin
            hdr_d   = or_val;
            lbad_d  = bad;
            p_v     = 1'b1;
            p.kind  = KIND_LENGTH;
            p.value = or_val[58:0];
            s_v     = bad;
            s.kind  = KIND_LENGTH_ERR;
            s.value = or_val[58:0];
          end
          8'd6: begin
            p_v     = 1'b1;
            p.kind  = KIND_TRIGTYPE;
            p.value = {55'b0, b[3:0]};
          end
          8'd10: begin
            hdr_d   = or_val;
            p_v     = 1'b1;
            p.kind  = KIND_TRIGNUM;
            p.value = 59'(or_val[31:0] + 32'd1);
          end
          8'd11, 8'd25: hdr_d = {53'b0, b, 3'b000};
          8'd12, 8'd13, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30: hdr_d = add_val;
          8'd14: begin
            hdr_d   = add_val;
            p_v     = 1'b1;
            p.kind  = KIND_TRIGTIME;
            p.value = add_val[58:0];
          end
          8'd15: begin
            p_v     = 1'b1;
            p.kind  = KIND_MODULE;
            p.value = 59'(b);
          end
          8'd20: begin
            hdr_d   = or_val;
            p_v     = 1'b1;
            p.kind  = KIND_LOCALNUM;
            p.value = 59'(or_val[31:0] + 32'd1);
          end
          8'd24: begin
            hdr_d   = or_val;
            pat_d   = or_val[31:0];
            p_v     = 1'b1;
            p.kind  = KIND_PATTERN;
            p.value = or_val[58:0];
          end
          8'd31: begin
            hdr_d   = add_val;
            p_v     = 1'b1;
            p.kind  = KIND_LOCALTIME;
            p.value = add_val[58:0];
          end
          default: ;
        endcase
      end else if (item_i.mode == MODE_SEVEN) begin
        if (item_i.a_in) begin
          case (item_i.a_ph)
            3'd0: peak_d = {16'b0, b};
            3'd1: peak_d = peak_q | {8'b0, b, 8'b0};
            3'd2: peak_d = peak_q | {b, 16'b0};
            3'd3: time_d = {21'b0, b, 3'b000};
            default: begin
              time_d = ta_sum;
              if (item_i.a_ph == A_PH_LAST && !lbad_q) begin
                p_v    = 1'b1;
                p.chan = {1'b0, item_i.a_idx};
                if (enable_i[{1'b0, item_i.a_idx}]) begin
                  p.kind = KIND_CHANNEL;
                  p.peak = peak_q;
                  p.tim  = ta_sum;
                  p.trig = pat_q[item_i.a_idx];
                end else begin
                  p.kind = KIND_ZEROED;
                end
              end
            end
          endcase
        end
      end else begin
        if (item_i.b_in) begin
          case (item_i.b_ph)
            3'd0: peak_d = {16'b0, b};
            3'd1: peak_d = peak_q | {8'b0, b, 8'b0};
            3'd2: time_d = {24'b0, b};
            3'd3: time_d = time_q | {16'b0, b, 8'b0};
            default: begin
              time_d = time_q | {8'b0, b, 16'b0};
              p_v    = 1'b1;
              p.kind = enable_i[item_i.b_idx] ? KIND_CHANNEL : KIND_ZEROED;
              p.chan = item_i.b_idx;
              p.peak = peak_q;
              p.tim  = time_q | {8'b0, b, 16'b0};
              p.trig = pat_q[{1'b0, item_i.b_idx[5:2]}];
            end
          endcase
        end
        if (item_i.g_in) begin
          case (item_i.g_ph)
            2'd0: ped_d = {4'b0, b};
            2'd1: begin
              ped_val = ped_q | {b[3:0], 8'b0};
              ped_d   = {8'b0, b[7:4]};
              s_v     = 1'b1;
              s.kind  = KIND_PEDESTAL;
              s.chan  = {item_i.g_idx[4:0], 1'b0};
              s.value = 59'(ped_val);
            end
            default: begin
              ped_val = ped_q + {b, 4'b0};
              s_v     = 1'b1;
              s.kind  = KIND_PEDESTAL;
              s.chan  = {item_i.g_idx[4:0], 1'b1};
              s.value = 59'(ped_val);
            end
          endcase
        end
      end
    end
    if (item_i.last) begin
      hdr_d  = '0;
      peak_d = '0;
      time_d = '0;
      ped_d  = '0;
      pat_d  = '0;
      lbad_d = 1'b0;
    end
  end

  // up to three results per item: main, side (length error or pedestal), end
  always_comb begin
    e      = '0;
    e.kind = KIND_END;
    e.last = 1'b1;
  end
  assign e_v   = item_i.last;
  assign cnt   = 2'(p_v) + 2'(s_v) + 2'(e_v);
  assign r0    = p_v ? p : (s_v ? s : e);
  assign r1    = (p_v && s_v) ? s : e;

  always_comb begin
    case (ridx_q)
      2'd0:    r_sel = r0;
      2'd1:    r_sel = r1;
      default: r_sel = e;
    endcase
  end

  assign head  = !empty_i;
  assign free  = !ov_q || out_ready_i;
  assign load  = head && (cnt != 2'd0) && free;
  assign pop_o = head && ((cnt == 2'd0) || (free && ridx_q == cnt - 2'd1));

  always_comb begin
    ridx_d = ridx_q;
    if (pop_o) begin
      ridx_d = '0;
    end else if (load) begin
      ridx_d = ridx_q + 2'd1;
    end
    ov_d  = load ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);
    out_d = load ? r_sel : out_q;
  end

  assign out_valid_o = ov_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q  <= '0;
      peak_q <= '0;
      time_q <= '0;
      ped_q  <= '0;
      pat_q  <= '0;
      lbad_q <= 1'b0;
      ridx_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        hdr_q  <= hdr_d;
        peak_q <= peak_d;
        time_q <= time_d;
        ped_q  <= ped_d;
        pat_q  <= pat_d;
        lbad_q <= lbad_d;
      end
      ridx_q <= ridx_d;
      ov_q   <= ov_d;
    end
  end

endmodule

// ===== design/adc_event_record_unpacker_core.sv =====
// ADC event record unpacker.
// Input stream: one record byte per item on s_axis, tlast on the final byte.
// Output stream: one decoded field per item on m_axis; tuser is the kind,
// tlast is set on the end-of-record item that follows the record's last byte.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_addr_i
// (0 record mode, 1 channel enable mask, 2 expected length); write only idle.
// Path: each byte is written into the input queue, and its results are decoded
// from the queue head into the output register. Throughput: one byte per cycle
// while each byte yields at most one result and m_axis_tready stays high; the
// output register sends one result per cycle, so a byte with two or three
// results holds the decode stage until all are sent, and the input queue (QUEUE_DEPTH items) takes up the slack.
// Reset clears the queue, the output valid flag and record state; registers
// return to mode 0, all channels enabled, expected length 256.
// When m_axis_tready is low the output item holds, the decode stage stops at
// the first byte with a result, and s_axis_tready drops once the queue is full.
module adc_event_record_unpacker_core
  import adcu_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // data_byte
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // channel, value, channel_peak, channel_time, triggered, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [3:0]          m_axis_tuser,   // kind
  output logic                m_axis_tlast,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic        mode_q, mode_d;
  logic [39:0] en_q, en_d;
  logic [31:0] exp_q, exp_d;
  logic        push, full, pop, empty;
  item_t       f_item, b_item;
  res_t        res;

  always_comb begin
    mode_d = mode_q;
    en_d   = en_q;
    exp_d  = exp_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_MODE:    mode_d = cfg_wdata_i[0];
        CFG_ENABLE:  en_d   = cfg_wdata_i;
        CFG_EXP_LEN: exp_d  = cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SEVEN;
      en_q   <= RST_ENABLE;
      exp_q  <= RST_EXP_LEN;
    end else begin
      mode_q <= mode_d;
      en_q   <= en_d;
      exp_q  <= exp_d;
    end
  end

  adcu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .mode_i     (mode_q),
    .q_full_i   (full),
    .push_o     (push),
    .item_o     (f_item)
  );

  adcu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (b_item),
    .empty_o (empty)
  );

  adcu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (b_item),
    .empty_i     (empty),
    .pop_o       (pop),
    .enable_i    (en_q),
    .exp_len_i   (exp_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {6'b0, res.trig, res.tim, res.peak, res.value, res.chan};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

// ===== design/adcu_chk.sv =====
module adcu_chk
  import adcu_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [7:0]          s_axis_tdata,
  input logic                s_axis_tlast,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [3:0]          m_axis_tuser,
  input logic                m_axis_tlast,
  input logic                cfg_we_i,
  input logic [CfgAddrW-1:0] cfg_addr_i,
  input logic [CfgDataW-1:0] cfg_wdata_i
);

  // end marker and tlast go together
  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 4'(KIND_END))))
    else $error("tlast and end kind disagree");

  // only channel items carry peak and time
  a_no_chan_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != 4'(KIND_CHANNEL)
      && m_axis_tuser != 4'(KIND_ZEROED)
    |-> m_axis_tdata[TD_TRIG:TD_PEAK] == '0)
    else $error("peak or time on a non-channel item");

  a_ped_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == 4'(KIND_PEDESTAL)
    |-> m_axis_tdata[TD_PEAK-1:TD_VALUE+12] == '0)
    else $error("pedestal wider than 12 bits");

  a_reset_quiet: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready
    |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
        && $stable(m_axis_tlast))
    else $error("stalled output item changed");

endmodule

bind adc_event_record_unpacker_core adcu_chk u_chk (.*);

// ===== tb/tb_adc_event_record_unpacker_core.sv =====
module tb_adc_event_record_unpacker_core;
  import adcu_pkg::*;

  localparam int FILL_RAND = 0;
  localparam int FILL_ZERO = 1;
  localparam int FILL_ONES = 2;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // data_byte
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // channel, value, channel_peak, channel_time, triggered, zero pad
  logic [OutDataW-1:0] m_axis_tdata;
  logic [3:0]          m_axis_tuser;   // kind
  logic                m_axis_tlast;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  adc_event_record_unpacker_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // decoder copy: registers
  logic        m_mode;
  logic [39:0] m_enable;
  logic [31:0] m_exp_len;
  // decoder copy: record state
  logic [7:0]  m_offs;
  logic        m_past;
  logic [63:0] m_hacc;
  logic [23:0] m_pacc;
  logic [31:0] m_tacc;
  logic [11:0] m_ped;
  logic [31:0] m_pat;
  logic        m_len_bad;

  res_t        field_q[$];
  logic [7:0]  rec_q[$];
  int          err_cnt;
  bit          idle_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void clear_record();
    m_offs    = '0;
    m_past    = 1'b0;
    m_hacc    = '0;
    m_pacc    = '0;
    m_tacc    = '0;
    m_ped     = '0;
    m_pat     = '0;
    m_len_bad = 1'b0;
  endfunction

  function automatic void push_field(kind_e k, int ch, logic [63:0] v, logic [23:0] pk,
                                     logic [31:0] tm, logic tr, logic ls);
    res_t r;
    r.kind  = k;
    r.chan  = ch[5:0];
    r.value = v[58:0];
    r.peak  = pk;
    r.tim   = tm;
    r.trig  = tr;
    r.last  = ls;
    field_q.push_back(r);
  endfunction

  function automatic void header_byte(int unsigned o, logic [63:0] bw);
    case (o)
      0, 7, 17, 21: m_hacc = bw;
      1, 2, 3: begin
        m_hacc = m_hacc | (bw << (8 * o));
        if (o == 3) begin
          push_field(KIND_LENGTH, 0, m_hacc, '0, '0, 1'b0, 1'b0);
          m_len_bad = (m_mode == MODE_SEVEN) && (m_hacc != {32'd0, m_exp_len});
          if (m_len_bad) push_field(KIND_LENGTH_ERR, 0, m_hacc, '0, '0, 1'b0, 1'b0);
        end
      end
      6: push_field(KIND_TRIGTYPE, 0, bw & 64'h0F, '0, '0, 1'b0, 1'b0);
      8, 9, 10: begin
        m_hacc = m_hacc | (bw << (8 * (o - 7)));
        if (o == 10)
          push_field(KIND_TRIGNUM, 0, (m_hacc + 64'd1) & 64'hFFFF_FFFF, '0, '0, 1'b0, 1'b0);
      end
      11, 25: m_hacc = bw * 64'd8;
      12, 13, 14: begin
        m_hacc = m_hacc + (bw << (8 * (o - 12))) * 64'd1000;
        if (o == 14) push_field(KIND_TRIGTIME, 0, m_hacc, '0, '0, 1'b0, 1'b0);
      end
      15: push_field(KIND_MODULE, 0, bw, '0, '0, 1'b0, 1'b0);
      18, 19, 20: begin
        m_hacc = m_hacc | (bw << (8 * (o - 17)));
        if (o == 20)
          push_field(KIND_LOCALNUM, 0, (m_hacc + 64'd1) & 64'hFFFF_FFFF, '0, '0, 1'b0, 1'b0);
      end
      22, 23, 24: begin
        m_hacc = m_hacc | (bw << (8 * (o - 21)));
        if (o == 24) begin
          m_pat = m_hacc[31:0];
          push_field(KIND_PATTERN, 0, m_hacc, '0, '0, 1'b0, 1'b0);
        end
      end
      26, 27, 28, 29, 30, 31: begin
        m_hacc = m_hacc + (bw << (8 * (o - 26))) * 64'd1000;
        if (o == 31) push_field(KIND_LOCALTIME, 0, m_hacc, '0, '0, 1'b0, 1'b0);
      end
      default: ;
    endcase
  endfunction

  function automatic void seven_byte(int unsigned o, logic [7:0] b);
    int unsigned rel, idx, ph;
    logic [63:0] t;
    rel = o - 32;
    idx = rel / 7;
    ph  = rel % 7;
    if (idx < MODE_A_CHANNELS) begin
      if (ph == 0) begin
        m_pacc = {16'd0, b};
      end else if (ph < 3) begin
        m_pacc = m_pacc | ({16'd0, b} << (8 * ph));
      end else if (ph == 3) begin
        m_tacc = {21'd0, b, 3'd0};
      end else begin
        t = {32'd0, m_tacc} + (({56'd0, b}) << (8 * (ph - 4))) * 64'd1000;
        m_tacc = t[31:0];
        if (ph == 6 && !m_len_bad) begin
          if (m_enable[idx])
            push_field(KIND_CHANNEL, idx, '0, m_pacc, m_tacc, m_pat[idx], 1'b0);
          else
            push_field(KIND_ZEROED, idx, '0, '0, '0, 1'b0, 1'b0);
        end
      end
    end
  endfunction

  function automatic void five_byte(int unsigned o, logic [7:0] b);
    int unsigned rel, k, ph, grp, q;
    logic [11:0] pv;
    kind_e kd;
    rel = o - 32;
    k   = rel / 5;
    ph  = rel % 5;
    if (k < MODE_B_CHANNELS) begin
      if (ph == 0) begin
        m_pacc = {16'd0, b};
      end else if (ph == 1) begin
        m_pacc = m_pacc | {8'd0, b, 8'd0};
      end else if (ph == 2) begin
        m_tacc = {24'd0, b};
      end else begin
        m_tacc = m_tacc | ({24'd0, b} << (8 * (ph - 2)));
        if (ph == 4) begin
          kd = m_enable[k] ? KIND_CHANNEL : KIND_ZEROED;
          push_field(kd, k, '0, m_pacc, m_tacc, m_pat[k / 4], 1'b0);
        end
      end
    end
    if (o >= 64) begin
      grp = (o - 64) / 3;
      q   = (o - 64) % 3;
      if (grp < PEDESTAL_GROUPS) begin
        if (q == 0) begin
          m_ped = {4'd0, b};
        end else if (q == 1) begin
          pv    = m_ped | {b[3:0], 8'd0};
          m_ped = {8'd0, b[7:4]};
          push_field(KIND_PEDESTAL, 2 * grp, {52'd0, pv}, '0, '0, 1'b0, 1'b0);
        end else begin
          pv = m_ped + {b, 4'd0};
          push_field(KIND_PEDESTAL, 2 * grp + 1, {52'd0, pv}, '0, '0, 1'b0, 1'b0);
        end
      end
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic lb);
    int unsigned o;
    if (!m_past) begin
      o = m_offs;
      if (o < 32) header_byte(o, {56'd0, b});
      else if (m_mode == MODE_SEVEN) seven_byte(o, b);
      else five_byte(o, b);
      if (m_offs == OFFS_MAX) m_past = 1'b1;
      else m_offs = m_offs + 8'd1;
    end
    if (lb) begin
      push_field(KIND_END, 0, '0, '0, '0, 1'b0, 1'b1);
      clear_record();
    end
  endfunction

  function automatic logic [39:0] rnd40();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[39:0];
  endfunction

  task automatic cmp(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  task automatic check_result();
    res_t e;
    if (field_q.size() == 0) begin
      err_cnt++;
      $display("%0t: unexpected item: expected none actual kind %0d data %0h",
               $time, m_axis_tuser, m_axis_tdata);
    end else begin
      e = field_q.pop_front();
      cmp("kind", e.kind, m_axis_tuser);
      cmp("channel", e.chan, m_axis_tdata[TD_CHAN +: 6]);
      cmp("value", e.value, m_axis_tdata[TD_VALUE +: 59]);
      cmp("peak", e.peak, m_axis_tdata[TD_PEAK +: 24]);
      cmp("time", e.tim, m_axis_tdata[TD_TIME +: 32]);
      cmp("triggered", e.trig, m_axis_tdata[TD_TRIG]);
      cmp("pad", '0, m_axis_tdata[OutDataW-1:TD_TRIG+1]);
      cmp("last", e.last, m_axis_tlast);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = rst_ni && (!idle_on || $urandom_range(99) >= 17);
    end
  end

  task automatic send_byte(logic [7:0] b, logic lb);
    if (idle_on && $urandom_range(99) < 20) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = lb;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(b, lb);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (field_q.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic set_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] v);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_MODE:    m_mode    = v[0];
      CFG_ENABLE:  m_enable  = v[39:0];
      CFG_EXP_LEN: m_exp_len = v[31:0];
      default: ;
    endcase
  endtask

  task automatic make_record(int n, logic [31:0] hdr_len, int fill);
    rec_q.delete();
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_ZERO: rec_q.push_back(8'h00);
        FILL_ONES: rec_q.push_back(8'hFF);
        default:   rec_q.push_back(8'($urandom));
      endcase
    end
    for (int i = 0; i < 4 && i < n; i++) rec_q[i] = hdr_len[8*i +: 8];
  endtask

  task automatic send_span(int first, int stop_at, bit mark_last);
    for (int i = first; i < stop_at; i++) send_byte(rec_q[i], mark_last && (i == stop_at - 1));
  endtask

  task automatic send_record(int n, logic [31:0] hdr_len, int fill);
    make_record(n, hdr_len, fill);
    send_span(0, n, 1'b1);
  endtask

  // reset values
  task automatic test_defaults();
    send_record(39, RST_EXP_LEN, FILL_RAND);
  endtask

  task automatic test_length_check();
    drain();
    set_reg(CFG_EXP_LEN, '0);
    send_record(39, 32'd5, FILL_RAND);
    drain();
    set_reg(CFG_EXP_LEN, 40'hFF_FFFF_FFFF);
    send_record(4, 32'hFFFF_FFFF, FILL_ONES);
  endtask

  task automatic test_channel_mask();
    drain();
    set_reg(CFG_EXP_LEN, {8'd0, 32'd256});
    set_reg(CFG_ENABLE, 40'hAA_AAAA_AAAA);
    send_record(39, 32'd256, FILL_RAND);
  endtask

  // every channel and pedestal, then offsets past the end, with no idling
  task automatic test_mode_five();
    drain();
    set_reg(CFG_MODE, {39'd0, MODE_FIVE});
    set_reg(CFG_ENABLE, rnd40());
    idle_on = 1'b0;
    send_record(258, $urandom, FILL_RAND);
    idle_on = 1'b1;
  endtask

  task automatic test_short_records();
    drain();
    set_reg(CFG_MODE, {39'd0, MODE_SEVEN});
    send_record(3, 32'd256, FILL_ZERO);
  endtask

  // mode flipped mid-record while the block is idle
  task automatic test_mode_switch();
    drain();
    make_record(38, 32'd256, FILL_RAND);
    send_span(0, 34, 1'b0);
    drain();
    set_reg(CFG_MODE, {39'd0, MODE_FIVE});
    send_span(34, 38, 1'b1);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    idle_on       = 1'b1;
    err_cnt       = 0;
    m_mode        = MODE_SEVEN;
    m_enable      = RST_ENABLE;
    m_exp_len     = RST_EXP_LEN;
    clear_record();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_defaults();
    test_length_check();
    test_channel_mask();
    test_mode_five();
    test_short_records();
    test_mode_switch();

    drain();
    repeat (20) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
